### design/psrf_pkg.sv
// Shared types, constants and the text-byte classifier for the string run finder.
`timescale 1ns / 1ps
`default_nettype none

package psrf_pkg;

	localparam int ADDR_W      = 64;
	localparam int ALEN_W      = 17;
	localparam int WLEN_W      = 16;
	localparam int CAP_W       = 17;
	localparam int MINLEN_W    = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int Q_DEPTH     = 4;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

	localparam logic [MINLEN_W-1:0] MIN_LEN_RESET    = 8'd4;
	localparam logic [CAP_W-1:0]    RESULT_CAP_RESET = 17'd100000;

	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_DEL   = 8'h7F;
	localparam logic [7:0] CHR_TAB   = 8'h09;
	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_CR    = 8'h0D;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_LEN    = 2'd0,
		REG_RESULT_CAP = 2'd1
	} cfg_reg_t;

	// one queue slot: the ASCII and the wide result caused by one byte
	typedef struct packed {
		logic              a_vld;
		logic [ADDR_W-1:0] a_start;
		logic [ALEN_W-1:0] a_len;
		logic              w_vld;
		logic [ADDR_W-1:0] w_start;
		logic [WLEN_W-1:0] w_len;
	} entry_t;

	function automatic logic is_text(input logic [7:0] b);
		return (b >= CHR_SPACE && b < CHR_DEL) || b == CHR_TAB || b == CHR_LF || b == CHR_CR;
	endfunction

endpackage

`default_nettype wire

### design/psrf_front.sv
// Front part: config registers, ASCII and wide run tracking, cap check per byte.
`timescale 1ns / 1ps
`default_nettype none

module psrf_front #(
	parameter int BUFFER_BYTES = 65536
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [psrf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [psrf_pkg::CAP_W-1:0]        cfg_data,
	input  wire logic                              accept,
	input  wire logic [7:0]                        data_byte,
	input  wire logic [psrf_pkg::ADDR_W-1:0]       byte_address,
	input  wire logic                              last_in_buffer,
	input  wire logic                              scan_start,
	output logic                                   push,
	output psrf_pkg::entry_t                       entry
);
	import psrf_pkg::*;

	localparam int ASCII_MAX = (BUFFER_BYTES < 131071) ? BUFFER_BYTES : 131071;
	localparam int WIDE_MAX  = ((BUFFER_BYTES / 2) < 65535) ? (BUFFER_BYTES / 2) : 65535;
	localparam logic [ALEN_W-1:0] ALEN_MAX = ALEN_W'(ASCII_MAX);
	localparam logic [WLEN_W-1:0] WLEN_MAX = WLEN_W'(WIDE_MAX);

	logic [MINLEN_W-1:0] min_len_q;
	logic [CAP_W-1:0]    cap_q;
	logic [ALEN_W-1:0]   a_len_q;
	logic [ADDR_W-1:0]   a_start_q;
	logic [WLEN_W-1:0]   w_len_q;
	logic [ADDR_W-1:0]   w_start_q;
	logic [7:0]          held_q;
	logic                odd_q;
	logic [CAP_W-1:0]    cnt_q;

	logic [MINLEN_W-1:0] need;
	logic                text, even, pair_ok;
	logic [ALEN_W-1:0]   a_len_inc, a_len_nx, a_emit_len;
	logic [ADDR_W-1:0]   a_start_nx, w_start_nx;
	logic [WLEN_W-1:0]   w_len_inc, w_len_nx, w_emit_len;
	logic                a_cand, w_cand, a_ok, w_ok;
	logic [CAP_W-1:0]    cnt0, cnt1, cnt2;

	always_comb begin
		need       = (min_len_q == '0) ? MINLEN_W'(1) : min_len_q;
		text       = is_text(data_byte);
		even       = !odd_q;
		a_len_inc  = (a_len_q < ALEN_MAX) ? a_len_q + ALEN_W'(1) : a_len_q;
		a_len_nx   = text ? a_len_inc : '0;
		a_start_nx = (text && a_len_q == '0) ? byte_address : a_start_q;
		a_emit_len = text ? a_len_inc : a_len_q;
		a_cand     = (!text || last_in_buffer) && a_emit_len != '0
		             && a_emit_len >= ALEN_W'(need);

		pair_ok    = data_byte == 8'h00 && is_text(held_q);
		w_len_inc  = (w_len_q < WLEN_MAX) ? w_len_q + WLEN_W'(1) : w_len_q;
		w_start_nx = (even && w_len_q == '0) ? byte_address : w_start_q;
		w_emit_len = (!even && pair_ok) ? w_len_inc : w_len_q;
		w_len_nx   = even ? w_len_q : (pair_ok ? w_len_inc : '0);
		w_cand     = (even ? last_in_buffer : (!pair_ok || last_in_buffer))
		             && w_emit_len != '0 && w_emit_len >= WLEN_W'(need);

		// ASCII result goes first and counts toward the cap for the wide one
		cnt0 = scan_start ? '0 : cnt_q;
		a_ok = a_cand && cnt0 < cap_q;
		cnt1 = cnt0 + CAP_W'(a_ok);
		w_ok = w_cand && cnt1 < cap_q;
		cnt2 = cnt1 + CAP_W'(w_ok);

		push          = accept && (a_ok || w_ok);
		entry.a_vld   = a_ok;
		entry.a_start = a_start_nx;
		entry.a_len   = a_emit_len;
		entry.w_vld   = w_ok;
		entry.w_start = w_start_nx;
		entry.w_len   = w_emit_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RESET;
			cap_q     <= RESULT_CAP_RESET;
			a_len_q   <= '0;
			a_start_q <= '0;
			w_len_q   <= '0;
			w_start_q <= '0;
			held_q    <= '0;
			odd_q     <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_LEN:    min_len_q <= cfg_data[MINLEN_W-1:0];
					REG_RESULT_CAP: cap_q     <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				a_start_q <= a_start_nx;
				w_start_q <= w_start_nx;
				cnt_q     <= cnt2;
				if (even)
					held_q <= data_byte;
				// buffer end drops both runs and realigns pairs
				a_len_q <= last_in_buffer ? '0 : a_len_nx;
				w_len_q <= last_in_buffer ? '0 : w_len_nx;
				odd_q   <= last_in_buffer ? 1'b0 : even;
			end
		end
	end

endmodule

`default_nettype wire

### design/psrf_queue.sv
// Short FIFO of per-byte result pairs between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module psrf_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire psrf_pkg::entry_t wr_entry,
	input  wire logic             pop,
	output psrf_pkg::entry_t      head,
	output logic                  empty,
	output logic                  full
);
	import psrf_pkg::*;

	entry_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	assign head  = mem_q[rd_ptr_q];
	assign empty = count_q == '0;
	assign full  = count_q == Q_CNT_W'(Q_DEPTH);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + Q_CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - Q_CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

### design/psrf_back.sv
// Back part: splits each queue slot into result beats behind an output register.
`timescale 1ns / 1ps
`default_nettype none

module psrf_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire psrf_pkg::entry_t            head,
	input  wire logic                        head_valid,
	output logic                             pop,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output logic [psrf_pkg::ADDR_W-1:0]      out_addr,
	output logic [psrf_pkg::ALEN_W-1:0]      out_len,
	output logic                             out_wide,
	output logic                             out_final
);
	import psrf_pkg::*;

	logic              valid_q, phase_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ALEN_W-1:0] len_q;
	logic              wide_q, final_q;
	logic              load, take, sel_wide, beat_final;

	always_comb begin
		load       = !valid_q || out_ready;
		take       = load && head_valid;
		// phase set: the ASCII half of this slot is already out
		sel_wide   = phase_q || !head.a_vld;
		beat_final = sel_wide || !head.w_vld;
		pop        = take && beat_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load)
				valid_q <= head_valid;
			if (take)
				phase_q <= !beat_final;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			addr_q  <= sel_wide ? head.w_start : head.a_start;
			len_q   <= sel_wide ? {1'b0, head.w_len} : head.a_len;
			wide_q  <= sel_wide;
			final_q <= beat_final;
		end
	end

	assign out_valid = valid_q;
	assign out_addr  = addr_q;
	assign out_len   = len_q;
	assign out_wide  = wide_q;
	assign out_final = final_q;

endmodule

`default_nettype wire

### design/printable_string_run_finder.sv
// Top level: ASCII / UTF-16LE printable string run finder, stream in and out.
// Takes one byte per cycle; s_tready drops only while the 4-slot result queue is full.
// Path: a result is written into the result queue, then into the back part's output register, which drives m_tvalid.
// Output: one beat per cycle while m_tready is high and results are queued; a byte ending both runs takes two beats.
// Reset (arst_n low, async): runs, pair position, result count and queue cleared;
// min_len returns to 4 and result_cap to 100000.
`timescale 1ns / 1ps
`default_nettype none

module printable_string_run_finder #(
	parameter int BUFFER_BYTES = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // data_byte[7:0], byte_address[71:8]
	input  wire logic        s_tlast,   // last_in_buffer
	input  wire logic        s_tuser,   // scan_start
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata,   // string_address[63:0], string_length[80:64], zero pad
	output logic             m_tlast,   // final_for_item
	output logic             m_tuser    // is_wide
);
	import psrf_pkg::*;

	logic              accept, push, pop, q_empty, q_full;
	entry_t            wr_entry, head;
	logic [ADDR_W-1:0] out_addr;
	logic [ALEN_W-1:0] out_len;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;

	psrf_front #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.accept        (accept),
		.data_byte     (s_tdata[7:0]),
		.byte_address  (s_tdata[71:8]),
		.last_in_buffer(s_tlast),
		.scan_start    (s_tuser),
		.push          (push),
		.entry         (wr_entry)
	);

	psrf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(wr_entry),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty),
		.full    (q_full)
	);

	psrf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(!q_empty),
		.pop       (pop),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_addr  (out_addr),
		.out_len   (out_len),
		.out_wide  (m_tuser),
		.out_final (m_tlast)
	);

	assign m_tdata = {7'b0, out_len, out_addr};

	// queue never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("result queue overflow");

	// only the ASCII half of a pair can be non-final
	a_nonfinal_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !m_tuser) else $error("non-final wide beat");

	// the wide half follows its ASCII half with no gap
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser && m_tlast))
		else $error("wide beat missing after ASCII beat");

endmodule

`default_nettype wire
